[design/fwt_pkg.sv]
// Shared constants, types and codes for the Fenwick tree range-sum block.
`default_nettype none
package fwt_pkg;

	// Store geometry
	localparam int MAX_ENTRIES = 1024;
	localparam int ADDR_W      = $clog2(MAX_ENTRIES);
	localparam int N_W         = ADDR_W + 1;
	localparam int K_W         = ADDR_W + 2;
	localparam int SUM_W       = 32;
	localparam int DELTA_W     = 16;
	localparam int STS_W       = 2;

	// Stream packing
	localparam int IN_TDATA_W  = 40;
	localparam int LO_LSB      = 0;
	localparam int HI_LSB      = ADDR_W;
	localparam int DELTA_LSB   = 2 * ADDR_W;
	localparam int OUT_TDATA_W = SUM_W;

	// Command codes
	localparam logic CMD_ADD   = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	// Status codes
	localparam logic [STS_W-1:0] STS_OK       = 2'd0;
	localparam logic [STS_W-1:0] STS_BEYOND   = 2'd1;
	localparam logic [STS_W-1:0] STS_INVERTED = 2'd2;

	// Size register reset value
	localparam logic [N_W-1:0] N_RESET = N_W'(MAX_ENTRIES);

	// Controller states, one-hot
	typedef enum logic [5:0] {
		ST_CLR  = 6'b000001,
		ST_IDLE = 6'b000010,
		ST_ADD  = 6'b000100,
		ST_QHI  = 6'b001000,
		ST_QLO  = 6'b010000,
		ST_FIN  = 6'b100000
	} state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic load;
		logic clr_step;
		logic add_step;
		logic qry_step;
		logic qry_sub;
		logic load_lo;
		logic out_load;
	} dp_cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic clr_last;
		logic k_zero;
		logic k_over;
		logic flagged;
		logic is_query;
	} dp_sts_t;

endpackage
`default_nettype wire

[design/fwt_ctrl.sv]
// Controller state machine for the Fenwick tree range-sum block.
`default_nettype none
module fwt_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  wire               m_tready,
	input  fwt_pkg::dp_sts_t  sts,
	output fwt_pkg::dp_cmd_t  cmd
);

	fwt_pkg::state_t state_q, state_d;
	logic            out_vld_q;
	logic            accept;

	assign s_tready = (state_q == fwt_pkg::ST_IDLE);
	assign m_tvalid = out_vld_q;
	assign accept   = s_tvalid & s_tready;

	// Decode next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			fwt_pkg::ST_CLR: begin
				cmd.clr_step = 1'b1;
				if (sts.clr_last) begin
					state_d = fwt_pkg::ST_IDLE;
				end
			end
			fwt_pkg::ST_IDLE: begin
				if (accept) begin
					cmd.load = 1'b1;
					if (sts.flagged) begin
						state_d = fwt_pkg::ST_FIN;
					end else if (sts.is_query) begin
						state_d = fwt_pkg::ST_QHI;
					end else begin
						state_d = fwt_pkg::ST_ADD;
					end
				end
			end
			fwt_pkg::ST_ADD: begin
				if (sts.k_over) begin
					state_d = fwt_pkg::ST_FIN;
				end else begin
					cmd.add_step = 1'b1;
				end
			end
			fwt_pkg::ST_QHI: begin
				if (sts.k_zero) begin
					cmd.load_lo = 1'b1;
					state_d     = fwt_pkg::ST_QLO;
				end else begin
					cmd.qry_step = 1'b1;
				end
			end
			fwt_pkg::ST_QLO: begin
				if (sts.k_zero) begin
					state_d = fwt_pkg::ST_FIN;
				end else begin
					cmd.qry_step = 1'b1;
					cmd.qry_sub  = 1'b1;
				end
			end
			fwt_pkg::ST_FIN: begin
				// Wait for the output register to free up
				if (!out_vld_q || m_tready) begin
					cmd.out_load = 1'b1;
					state_d      = fwt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = fwt_pkg::ST_IDLE;
			end
		endcase
	end

	// Hold state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= fwt_pkg::ST_CLR;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

[design/fwt_dpath.sv]
// Datapath for the Fenwick tree range-sum block: tree memory, walk index, accumulator.
`default_nettype none
module fwt_dpath (
	input  wire                                  clk,
	input  wire                                  arst_n,
	input  wire                                  cfg_we,
	input  wire  [fwt_pkg::N_W-1:0]              cfg_wdata,
	input  wire  [fwt_pkg::IN_TDATA_W-1:0]       s_tdata,
	input  wire                                  s_tuser,
	input  fwt_pkg::dp_cmd_t                     cmd,
	output fwt_pkg::dp_sts_t                     sts,
	output logic [fwt_pkg::OUT_TDATA_W-1:0]      m_tdata,
	output logic [fwt_pkg::STS_W-1:0]            m_tuser
);

	localparam int ADDR_W = fwt_pkg::ADDR_W;
	localparam int N_W    = fwt_pkg::N_W;
	localparam int K_W    = fwt_pkg::K_W;
	localparam int SUM_W  = fwt_pkg::SUM_W;

	logic [SUM_W-1:0]  mem [fwt_pkg::MAX_ENTRIES];
	logic [SUM_W-1:0]  rdata_s1;
	logic [ADDR_W-1:0] addr_s1;
	logic              acc_en_s1, sub_s1, wb_s1;

	logic [N_W-1:0]    n_q;
	logic [K_W-1:0]    k_q;
	logic [ADDR_W-1:0] lo_q;
	logic [SUM_W-1:0]  amount_q;
	logic [SUM_W-1:0]  acc_q;
	logic [fwt_pkg::STS_W-1:0] status_q;
	logic [ADDR_W-1:0] clr_q;

	logic [ADDR_W-1:0] in_lo, in_hi;
	logic [fwt_pkg::DELTA_W-1:0] in_delta;
	logic              beyond, inverted;
	logic [fwt_pkg::STS_W-1:0] in_status;
	logic [K_W-1:0]    lowbit;
	logic [K_W-1:0]    k_m1;
	logic [ADDR_W-1:0] rd_addr;
	logic              mem_we;
	logic [ADDR_W-1:0] wr_addr;
	logic [SUM_W-1:0]  wr_data;

	// Unpack request fields and check them against the size in use
	assign in_lo    = s_tdata[fwt_pkg::LO_LSB +: ADDR_W];
	assign in_hi    = s_tdata[fwt_pkg::HI_LSB +: ADDR_W];
	assign in_delta = s_tdata[fwt_pkg::DELTA_LSB +: fwt_pkg::DELTA_W];

	always_comb begin
		beyond   = ({1'b0, in_lo} >= n_q) ||
		           ((s_tuser == fwt_pkg::CMD_QUERY) && ({1'b0, in_hi} >= n_q));
		inverted = (s_tuser == fwt_pkg::CMD_QUERY) && (in_lo > in_hi);
		if (beyond) begin
			in_status = fwt_pkg::STS_BEYOND;
		end else if (inverted) begin
			in_status = fwt_pkg::STS_INVERTED;
		end else begin
			in_status = fwt_pkg::STS_OK;
		end
	end

	// Walk helpers: lowest set bit and memory address of tree index k
	assign lowbit  = k_q & (~k_q + K_W'(1));
	assign k_m1    = k_q - K_W'(1);
	assign rd_addr = k_m1[ADDR_W-1:0];

	assign sts.clr_last = (clr_q == {ADDR_W{1'b1}});
	assign sts.k_zero   = (k_q == '0);
	assign sts.k_over   = (k_q > K_W'(n_q));
	assign sts.flagged  = (in_status != fwt_pkg::STS_OK);
	assign sts.is_query = (s_tuser == fwt_pkg::CMD_QUERY);

	// Write port: clearing pass or add write-back
	assign mem_we  = cmd.clr_step | wb_s1;
	assign wr_addr = cmd.clr_step ? clr_q : addr_s1;
	assign wr_data = cmd.clr_step ? '0 : (rdata_s1 + amount_q);

	// Tree memory, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[wr_addr] <= wr_data;
		end
		rdata_s1 <= mem[rd_addr];
		addr_s1  <= rd_addr;
	end

	// Control registers: size, clear counter, read pipeline flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_q       <= fwt_pkg::N_RESET;
			clr_q     <= '0;
			acc_en_s1 <= 1'b0;
			sub_s1    <= 1'b0;
			wb_s1     <= 1'b0;
		end else begin
			if (cfg_we) begin
				n_q <= (cfg_wdata > fwt_pkg::N_RESET) ? fwt_pkg::N_RESET : cfg_wdata;
			end
			if (cmd.clr_step) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			acc_en_s1 <= cmd.qry_step;
			sub_s1    <= cmd.qry_sub;
			wb_s1     <= cmd.add_step;
		end
	end

	// Walk index, request fields and accumulator
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			k_q      <= (s_tuser == fwt_pkg::CMD_QUERY) ? (K_W'(in_hi) + K_W'(1))
			                                            : (K_W'(in_lo) + K_W'(1));
			lo_q     <= in_lo;
			amount_q <= {{(SUM_W - fwt_pkg::DELTA_W){in_delta[fwt_pkg::DELTA_W-1]}}, in_delta};
			status_q <= in_status;
		end else if (cmd.load_lo) begin
			k_q <= K_W'(lo_q);
		end else if (cmd.qry_step) begin
			k_q <= k_q - lowbit;
		end else if (cmd.add_step) begin
			k_q <= k_q + lowbit;
		end

		if (cmd.load) begin
			acc_q <= '0;
		end else if (acc_en_s1) begin
			acc_q <= sub_s1 ? (acc_q - rdata_s1) : (acc_q + rdata_s1);
		end

		if (cmd.out_load) begin
			m_tdata <= acc_q;
			m_tuser <= status_q;
		end
	end

endmodule
`default_nettype wire

[design/fenwick_tree_range_sum.sv]
// Top level of the Fenwick tree range-sum block.
//
// A request enters on the s_ channel: s_tuser selects add (0) or range sum (1),
// s_tdata carries pos_lo, pos_hi and a signed 16-bit delta. Each request gives
// one result on the m_ channel: m_tdata is the 32-bit signed range sum (zero for
// an add or a rejected request), m_tuser the status (ok, beyond size, inverted).
// cfg_we/cfg_wdata write the number of positions in use (saturated at 1024);
// write it only while the block is idle. Changing it keeps the tree contents.
// An add walks the tree upward from pos_lo+1; a range sum walks downward from
// pos_hi+1 adding, then from pos_lo subtracting. The walks do one tree memory
// read per cycle through the registered read port. A rejected request skips
// the walk. One request is worked at a time.
// After reset the tree memory is swept to zero with s_tready low.
// A finished result sits in an output register; while the receiver stalls the
// block may accept and work the next request, holding it before the output
// until the waiting result is taken.
`default_nettype none
module fenwick_tree_range_sum (
	input  wire                                clk,
	input  wire                                arst_n,
	input  wire                                cfg_we,
	input  wire  [fwt_pkg::N_W-1:0]            cfg_wdata,
	input  wire                                s_tvalid,
	output logic                               s_tready,
	input  wire  [fwt_pkg::IN_TDATA_W-1:0]     s_tdata,  // pos_lo, pos_hi, delta, zero pad
	input  wire                                s_tuser,  // cmd
	output logic                               m_tvalid,
	input  wire                                m_tready,
	output logic [fwt_pkg::OUT_TDATA_W-1:0]    m_tdata,  // range_sum
	output logic [fwt_pkg::STS_W-1:0]          m_tuser   // status
);

	fwt_pkg::dp_cmd_t cmd;
	fwt_pkg::dp_sts_t sts;

	fwt_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fwt_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.cmd       (cmd),
		.sts       (sts),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

endmodule
`default_nettype wire
